>>> rtl/core/dtq_pkg.sv
// dtq_pkg: shared types, codes and time arithmetic for the delta timer queue
// used by the controller, datapath and top level; depends on nothing
package dtq_pkg;

  localparam logic [19:0] MILLION = 20'd1000000;
  localparam logic [30:0] SEC_MAX = 31'h7FFFFFFF;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_NEXT   = 3'd3,
    OP_ALARM  = 3'd4
  } op_t;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic [30:0] sec;
    logic [19:0] usec;
  } time_t;

  // datapath actions
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SYNC_START,
    CMD_RD_IDX,
    CMD_RD_IP1,
    CMD_RD_JM1,
    CMD_RD_HEAD,
    CMD_SYNC_COVER,
    CMD_SYNC_REDUCE,
    CMD_IDX_CLR,
    CMD_IDX_INC,
    CMD_HOLD,
    CMD_RM_SHIFT,
    CMD_CNT_DEC,
    CMD_ADD_WALK,
    CMD_JDX_LOAD,
    CMD_ADD_SHIFT,
    CMD_ADD_PUT,
    CMD_EMIT
  } cmd_op_t;

  // result staging actions
  typedef enum logic [2:0] {
    SET_KEEP,
    SET_OK,
    SET_NOTFOUND,
    SET_FULL,
    SET_EMPTY,
    SET_REMOVED,
    SET_NEXT,
    SET_POP
  } set_t;

  typedef struct packed {
    cmd_op_t op;
    set_t    set;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_lt_cnt;
    logic       ip1_lt_cnt;
    logic       jdx_gt_idx;
    logic       full;
    logic       empty;
    logic       ge_acc;
    logic       ge_nd;
    logic       rd_zero;
    logic       tok_match;
    logic       sync_back;
    logic       out_free;
  } stat_t;

  function automatic logic ge(time_t a, time_t b);
    return (a.sec > b.sec) || ((a.sec == b.sec) && (a.usec >= b.usec));
  endfunction

  // a - b, saturating at zero
  function automatic time_t sub_sat(time_t a, time_t b);
    time_t r;
    r = '0;
    if (ge(a, b)) begin
      if (a.usec < b.usec) begin
        r.usec = 20'(21'(a.usec) + 21'(MILLION) - 21'(b.usec));
        r.sec  = a.sec - b.sec - 31'd1;
      end else begin
        r.usec = a.usec - b.usec;
        r.sec  = a.sec - b.sec;
      end
    end
    return r;
  endfunction

  // fold an out-of-range microsecond part into the seconds
  function automatic time_t norm(time_t a);
    time_t r;
    r = a;
    if (a.usec >= MILLION) begin
      r.usec = a.usec - MILLION;
      if (a.sec < SEC_MAX) begin
        r.sec = a.sec + 31'd1;
      end else begin
        r.usec = MILLION - 20'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/delta_timer_queue.sv
// delta_timer_queue: bounded timer queue kept as a sorted delta list in ram
// depends on dtq_pkg, dtq_ctrl, dtq_datapath (which holds dtq_ram)
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata times, token
//  m_      | out | m_tvalid/m_tready  | m_tuser status, m_tdata token, next time
//
// one item at a time; each walk over the list does, for each entry visited,
// a ram read, then a compare, a write back or both; the walks are sync,
// search, insert walk and shift
// rst is synchronous; no clearing pass, entries are only read below the count
// a result waits in the output register while the next item is taken
module delta_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // token[31:0], delay_sec[62:32], delay_usec[82:63], now_sec[113:83],
  // now_usec[133:114], zero fill
  input  logic [135:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_token[31:0], next_sec[62:32], next_usec[82:63], zero fill
  output logic [87:0]  m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);
  import dtq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dtq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  dtq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

>>> rtl/core/dtq_ram.sv
// dtq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/dtq_datapath.sv
// dtq_datapath: entry ram, time registers, index counters and result register
// depends on dtq_pkg and dtq_ram
module dtq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [135:0]   s_tdata,
  input  logic [2:0]     s_tuser,
  output logic [87:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  dtq_pkg::cmd_t  cmd,
  output dtq_pkg::stat_t stat
);
  import dtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 83;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [2:0]    op_q;
  logic [31:0]   tok_q;
  time_t         nd, now_q, last, acc, hold;
  logic          first;
  logic [CW-1:0] idx, jdx, cnt;
  logic [1:0]    res_status;
  logic [31:0]   res_tok;
  time_t         res_time;
  logic [1:0]    out_status;
  logic [31:0]   out_tok;
  time_t         out_time;
  logic          out_valid;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [31:0]   rd_tok;
  time_t         rd_t;
  time_t         in_delay, in_now;
  logic [CW-1:0] ip1, jm1;
  time_t         merged, w_t;
  logic [31:0]   w_tok;

  // delay sum of a removed entry and its successor, saturating
  function automatic time_t add_sat(time_t a, time_t b);
    logic [31:0] s;
    logic [20:0] u;
    time_t       r;
    s = {1'b0, a.sec} + {1'b0, b.sec};
    u = {1'b0, a.usec} + {1'b0, b.usec};
    if (u >= 21'(MILLION)) begin
      u = u - 21'(MILLION);
      s = s + 32'd1;
    end
    if (s > {1'b0, SEC_MAX}) begin
      r.sec  = SEC_MAX;
      r.usec = MILLION - 20'd1;
    end else begin
      r.sec  = s[30:0];
      r.usec = u[19:0];
    end
    return r;
  endfunction

  // input fields
  assign in_delay = norm('{sec: s_tdata[62:32], usec: s_tdata[82:63]});
  assign in_now   = norm('{sec: s_tdata[113:83], usec: s_tdata[133:114]});

  assign rd_tok = rdata[31:0];
  assign rd_t   = '{sec: rdata[62:32], usec: rdata[82:63]};
  assign ip1    = idx + 1'b1;
  assign jm1    = jdx - 1'b1;
  assign merged = add_sat(rd_t, hold);

  // status toward the controller
  always_comb begin
    stat.op         = op_q;
    stat.idx_lt_cnt = idx < cnt;
    stat.ip1_lt_cnt = ip1 < cnt;
    stat.jdx_gt_idx = jdx > idx;
    stat.full       = cnt >= DEPTH_C;
    stat.empty      = cnt == '0;
    stat.ge_acc     = ge(acc, rd_t);
    stat.ge_nd      = ge(nd, rd_t);
    stat.rd_zero    = (rd_t.sec == '0) && (rd_t.usec == '0);
    stat.tok_match  = rd_tok == tok_q;
    stat.sync_back  = !ge(now_q, last);
    stat.out_free   = !out_valid || m_tready;
  end

  // ram read address
  always_comb begin
    re    = 1'b1;
    raddr = idx[AW-1:0];
    case (cmd.op)
      CMD_RD_IDX:  raddr = idx[AW-1:0];
      CMD_RD_IP1:  raddr = ip1[AW-1:0];
      CMD_RD_JM1:  raddr = jm1[AW-1:0];
      CMD_RD_HEAD: raddr = '0;
      default:     re = 1'b0;
    endcase
  end

  // ram write port
  always_comb begin
    we    = 1'b1;
    waddr = idx[AW-1:0];
    w_tok = rd_tok;
    w_t   = rd_t;
    case (cmd.op)
      CMD_SYNC_COVER:  w_t = '0;
      CMD_SYNC_REDUCE: w_t = sub_sat(rd_t, acc);
      CMD_RM_SHIFT:    w_t = first ? merged : rd_t;
      CMD_ADD_SHIFT: begin
        waddr = jdx[AW-1:0];
        w_t   = (jm1 == idx) ? sub_sat(rd_t, nd) : rd_t;
      end
      CMD_ADD_PUT: begin
        w_tok = tok_q;
        w_t   = nd;
      end
      default: we = 1'b0;
    endcase
    wdata = {w_t.usec, w_t.sec, w_tok};
  end

  dtq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // control registers: count, last sync time, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      last      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == CMD_SYNC_START) begin
        last <= now_q;
      end
      if (cmd.op == CMD_ADD_PUT) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.op == CMD_CNT_DEC) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.op == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        op_q  <= s_tuser;
        tok_q <= s_tdata[31:0];
        nd    <= in_delay;
        now_q <= in_now;
        idx   <= '0;
      end
      CMD_SYNC_START: begin
        acc <= sub_sat(now_q, last);
        idx <= '0;
      end
      CMD_SYNC_COVER: begin
        acc <= sub_sat(acc, rd_t);
        idx <= idx + 1'b1;
      end
      CMD_IDX_CLR:  idx <= '0;
      CMD_IDX_INC:  idx <= idx + 1'b1;
      CMD_HOLD: begin
        hold  <= rd_t;
        first <= 1'b1;
      end
      CMD_RM_SHIFT: begin
        first <= 1'b0;
        idx   <= idx + 1'b1;
      end
      CMD_ADD_WALK: begin
        nd  <= sub_sat(nd, rd_t);
        idx <= idx + 1'b1;
      end
      CMD_JDX_LOAD:  jdx <= cnt;
      CMD_ADD_SHIFT: jdx <= jm1;
      CMD_EMIT: begin
        out_status <= res_status;
        out_tok    <= res_tok;
        out_time   <= res_time;
      end
      default: ;
    endcase
  end

  // result staging
  always_ff @(posedge clk) begin
    case (cmd.set)
      SET_OK: begin
        res_status <= ST_OK;
        res_tok    <= '0;
        res_time   <= '0;
      end
      SET_NOTFOUND: begin
        res_status <= ST_NOTFOUND;
        res_tok    <= '0;
        res_time   <= '0;
      end
      SET_FULL: begin
        res_status <= ST_FULL;
        res_tok    <= '0;
        res_time   <= '0;
      end
      SET_EMPTY: begin
        res_status <= ST_NONE;
        res_tok    <= '0;
        res_time   <= '0;
      end
      SET_REMOVED: begin
        res_status <= ST_OK;
        res_tok    <= tok_q;
        res_time   <= '0;
      end
      SET_NEXT: begin
        res_status <= ST_OK;
        res_tok    <= '0;
        res_time   <= rd_t;
      end
      SET_POP: begin
        res_status <= ST_OK;
        res_tok    <= rd_tok;
        res_time   <= '0;
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {5'b0, out_time.usec, out_time.sec, out_tok};

  // count stays within the queue depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= DEPTH_C)
    else $error("entry count above depth");
  // an insert only happens with room left
  a_put_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_ADD_PUT) |-> (cnt < DEPTH_C))
    else $error("insert into a full queue");
  // a result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_EMIT) |-> (!out_valid || m_tready))
    else $error("result overwritten");
  // removal only with entries present
  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_CNT_DEC) |-> (cnt != '0))
    else $error("remove from an empty queue");

endmodule

>>> rtl/core/dtq_ctrl.sv
// dtq_ctrl: sequencer that walks the delta list for each operation
// depends on dtq_pkg
module dtq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  dtq_pkg::stat_t stat,
  output dtq_pkg::cmd_t  cmd
);
  import dtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SYNC_BEGIN, S_SYNC_RD, S_SYNC_CHK,
    S_ADD_CHECK, S_ADD_RD, S_ADD_CHK, S_ADD_PREP, S_ADD_SHRD, S_ADD_SHWR,
    S_ADD_PUT, S_FIND_RD, S_FIND_CHK, S_RM_HOLD, S_RM_RD, S_RM_WR,
    S_HEAD_CHK, S_NEXT_RD, S_NEXT_SET, S_ALARM_RD, S_ALARM_CHK, S_EMIT
  } state_t;

  state_t state, state_next, ret, ret_next;

  assign s_tready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = CMD_NOP;
    cmd.set    = SET_KEEP;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD: begin
            ret_next   = S_ADD_CHECK;
            state_next = S_SYNC_BEGIN;
          end
          OP_UPDATE, OP_REMOVE: state_next = S_FIND_RD;
          OP_NEXT, OP_ALARM: begin
            if (stat.empty) begin
              cmd.set    = SET_EMPTY;
              state_next = S_EMIT;
            end else begin
              cmd.op     = CMD_RD_HEAD;
              state_next = S_HEAD_CHK;
            end
          end
          default: begin
            cmd.set    = SET_EMPTY;
            state_next = S_EMIT;
          end
        endcase
      end
      S_SYNC_BEGIN: begin
        cmd.op     = CMD_SYNC_START;
        state_next = stat.sync_back ? ret : S_SYNC_RD;
      end
      S_SYNC_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.op     = CMD_RD_IDX;
          state_next = S_SYNC_CHK;
        end else begin
          state_next = ret;
        end
      end
      S_SYNC_CHK: begin
        if (stat.ge_acc) begin
          cmd.op     = CMD_SYNC_COVER;
          state_next = S_SYNC_RD;
        end else begin
          cmd.op     = CMD_SYNC_REDUCE;
          state_next = ret;
        end
      end
      S_ADD_CHECK: begin
        if (stat.full) begin
          cmd.set    = SET_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.op     = CMD_IDX_CLR;
          state_next = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.op     = CMD_RD_IDX;
          state_next = S_ADD_CHK;
        end else begin
          state_next = S_ADD_PREP;
        end
      end
      S_ADD_CHK: begin
        if (stat.ge_nd) begin
          cmd.op     = CMD_ADD_WALK;
          state_next = S_ADD_RD;
        end else begin
          state_next = S_ADD_PREP;
        end
      end
      S_ADD_PREP: begin
        cmd.op     = CMD_JDX_LOAD;
        state_next = S_ADD_SHRD;
      end
      S_ADD_SHRD: begin
        if (stat.jdx_gt_idx) begin
          cmd.op     = CMD_RD_JM1;
          state_next = S_ADD_SHWR;
        end else begin
          state_next = S_ADD_PUT;
        end
      end
      S_ADD_SHWR: begin
        cmd.op     = CMD_ADD_SHIFT;
        state_next = S_ADD_SHRD;
      end
      S_ADD_PUT: begin
        cmd.op     = CMD_ADD_PUT;
        cmd.set    = SET_OK;
        state_next = S_EMIT;
      end
      S_FIND_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.op     = CMD_RD_IDX;
          state_next = S_FIND_CHK;
        end else begin
          cmd.set    = SET_NOTFOUND;
          state_next = S_EMIT;
        end
      end
      S_FIND_CHK: begin
        if (stat.tok_match) begin
          state_next = S_RM_HOLD;
        end else begin
          cmd.op     = CMD_IDX_INC;
          state_next = S_FIND_RD;
        end
      end
      S_RM_HOLD: begin
        cmd.op     = CMD_HOLD;
        state_next = S_RM_RD;
      end
      S_RM_RD: begin
        if (stat.ip1_lt_cnt) begin
          cmd.op     = CMD_RD_IP1;
          state_next = S_RM_WR;
        end else begin
          cmd.op = CMD_CNT_DEC;
          if (stat.op == OP_UPDATE) begin
            ret_next   = S_ADD_CHECK;
            state_next = S_SYNC_BEGIN;
          end else begin
            if (stat.op == OP_REMOVE) begin
              cmd.set = SET_REMOVED;
            end
            state_next = S_EMIT;
          end
        end
      end
      S_RM_WR: begin
        cmd.op     = CMD_RM_SHIFT;
        state_next = S_RM_RD;
      end
      S_HEAD_CHK: begin
        if (stat.rd_zero) begin
          if (stat.op == OP_NEXT) begin
            cmd.set    = SET_OK;
            state_next = S_EMIT;
          end else begin
            cmd.set    = SET_POP;
            state_next = S_RM_HOLD;
          end
        end else begin
          ret_next   = (stat.op == OP_NEXT) ? S_NEXT_RD : S_ALARM_RD;
          state_next = S_SYNC_BEGIN;
        end
      end
      S_NEXT_RD: begin
        cmd.op     = CMD_RD_HEAD;
        state_next = S_NEXT_SET;
      end
      S_NEXT_SET: begin
        cmd.set    = SET_NEXT;
        state_next = S_EMIT;
      end
      S_ALARM_RD: begin
        cmd.op     = CMD_RD_HEAD;
        state_next = S_ALARM_CHK;
      end
      S_ALARM_CHK: begin
        if (stat.rd_zero) begin
          cmd.op     = CMD_IDX_CLR;
          cmd.set    = SET_POP;
          state_next = S_RM_HOLD;
        end else begin
          cmd.set    = SET_EMPTY;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule
